>>> rtl/core/msa_pkg.sv
// Shared types, codes and reset values for the motor stall alarm block.
// No dependencies; used by every module under rtl/core.
`default_nettype none

package msa_pkg;

	// Fixed widths of the item fields that do not scale with a parameter
	localparam int CFG_BITS = 16;
	localparam int RPM_BITS = 16;
	localparam int DIR_BITS = 2;
	localparam int MODE_BITS = 2;

	// Field bits of an input item other than the speed setpoint
	localparam int IN_FIXED_BITS = 3 + 1 + DIR_BITS + RPM_BITS;
	// Field bits of a result item other than the speed setpoint
	localparam int RES_FIXED_BITS = MODE_BITS + 1 + DIR_BITS + 1 + 1;

	// Parameter defaults
	localparam int SPEED_BITS_DEF = 10;
	localparam int TIMER_BITS_DEF = 16;

	// Register reset values
	localparam logic [CFG_BITS-1:0] STALL_TICKS_RST = 16'd1000;
	localparam logic [CFG_BITS-1:0] ALARM_TICKS_RST = 16'd5000;
	localparam logic [CFG_BITS-1:0] BUZZ_HALF_RST = 16'd250;

	// Direction codes
	localparam logic [DIR_BITS-1:0] DIR_STOP = 2'd0;
	localparam logic [DIR_BITS-1:0] DIR_CW = 2'd1;
	localparam logic [DIR_BITS-1:0] DIR_CCW = 2'd2;
	localparam logic [DIR_BITS-1:0] DIR_BAD = 2'd3;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_STOPPED = 2'd0,
		MODE_RUNNING = 2'd1,
		MODE_ALARM = 2'd2,
		MODE_FAULT = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CFG_STALL_TICKS = 2'd0,
		CFG_ALARM_TICKS = 2'd1,
		CFG_BUZZ_HALF = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] stall_ticks;
		logic [CFG_BITS-1:0] alarm_ticks;
		logic [CFG_BITS-1:0] buzzer_half_period;
	} cfg_regs_t;

endpackage

`default_nettype wire

>>> rtl/core/msa_cfg_regs.sv
// Configuration register file: stall, alarm and buzzer timing.
// Depends on msa_pkg.
`default_nettype none

module msa_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [1:0]                       wr_index,
	input  wire logic [msa_pkg::CFG_BITS-1:0]     wr_data,
	output msa_pkg::cfg_regs_t                    cfg
);

	msa_pkg::cfg_regs_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stall_ticks <= msa_pkg::STALL_TICKS_RST;
			cfg_q.alarm_ticks <= msa_pkg::ALARM_TICKS_RST;
			cfg_q.buzzer_half_period <= msa_pkg::BUZZ_HALF_RST;
		end else if (wr_en) begin
			unique case (msa_pkg::cfg_idx_t'(wr_index))
				msa_pkg::CFG_STALL_TICKS: cfg_q.stall_ticks <= wr_data;
				msa_pkg::CFG_ALARM_TICKS: cfg_q.alarm_ticks <= wr_data;
				msa_pkg::CFG_BUZZ_HALF: cfg_q.buzzer_half_period <= wr_data;
				default: ; // unused index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> rtl/core/msa_core.sv
// Supervisor state machine: mode, drive, stall/alarm/buzzer timers, one tick per step.
// Depends on msa_pkg.
`default_nettype none

module msa_core #(
	parameter int SPEED_BITS = msa_pkg::SPEED_BITS_DEF,
	parameter int TIMER_BITS = msa_pkg::TIMER_BITS_DEF
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          step,
	input  wire msa_pkg::cfg_regs_t                            cfg,
	input  wire logic [msa_pkg::IN_FIXED_BITS+SPEED_BITS-1:0]  item,
	output logic [msa_pkg::RES_FIXED_BITS+SPEED_BITS-1:0]      res
);

	localparam int CMP_W = (TIMER_BITS > msa_pkg::CFG_BITS) ? TIMER_BITS : msa_pkg::CFG_BITS;
	localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

	// item unpack, lowest field first
	logic                             start_press, stop_press, speed_valid, dir_toggle;
	logic [SPEED_BITS-1:0]            speed_value;
	logic [msa_pkg::DIR_BITS-1:0]     measured_dir;
	logic [msa_pkg::RPM_BITS-1:0]     rpm_value;
	logic                             turning;

	assign start_press = item[0];
	assign stop_press = item[1];
	assign speed_valid = item[2];
	assign speed_value = item[3 +: SPEED_BITS];
	assign dir_toggle = item[3+SPEED_BITS];
	assign measured_dir = item[4+SPEED_BITS +: msa_pkg::DIR_BITS];
	assign rpm_value = item[6+SPEED_BITS +: msa_pkg::RPM_BITS];
	assign turning = (rpm_value != '0);

	msa_pkg::mode_t                 mode_q, mode_d;
	logic [SPEED_BITS-1:0]          speed_q, speed_d;
	logic [msa_pkg::DIR_BITS-1:0]   dir_q, dir_d;
	logic                           motor_q, motor_d;
	logic                           armed_q, armed_d;
	logic [TIMER_BITS-1:0]          stall_cnt_q, stall_cnt_d;
	logic [TIMER_BITS-1:0]          alarm_cnt_q, alarm_cnt_d;
	logic [TIMER_BITS-1:0]          buzz_cnt_q, buzz_cnt_d;
	logic                           led_q, led_d;
	logic                           alarm_q, alarm_d;

	// saturating increments
	logic [TIMER_BITS-1:0] stall_inc, alarm_inc, buzz_inc;
	assign stall_inc = (stall_cnt_q == TMAX) ? stall_cnt_q : stall_cnt_q + 1'b1;
	assign alarm_inc = (alarm_cnt_q == TMAX) ? alarm_cnt_q : alarm_cnt_q + 1'b1;
	assign buzz_inc = (buzz_cnt_q == TMAX) ? buzz_cnt_q : buzz_cnt_q + 1'b1;

	logic stall_hit, alarm_hit, buzz_hit;
	assign stall_hit = CMP_W'(stall_inc) >= CMP_W'(cfg.stall_ticks);
	assign alarm_hit = CMP_W'(alarm_inc) >= CMP_W'(cfg.alarm_ticks);
	assign buzz_hit = CMP_W'(buzz_inc) >= CMP_W'(cfg.buzzer_half_period);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= msa_pkg::MODE_STOPPED;
			speed_q <= '0;
			dir_q <= msa_pkg::DIR_STOP;
			motor_q <= 1'b0;
			armed_q <= 1'b0;
			stall_cnt_q <= '0;
			alarm_cnt_q <= '0;
			buzz_cnt_q <= '0;
			led_q <= 1'b0;
			alarm_q <= 1'b0;
		end else if (step) begin
			mode_q <= mode_d;
			speed_q <= speed_d;
			dir_q <= dir_d;
			motor_q <= motor_d;
			armed_q <= armed_d;
			stall_cnt_q <= stall_cnt_d;
			alarm_cnt_q <= alarm_cnt_d;
			buzz_cnt_q <= buzz_cnt_d;
			led_q <= led_d;
			alarm_q <= alarm_d;
		end
	end

	always_comb begin
		mode_d = mode_q;
		speed_d = speed_q;
		dir_d = dir_q;
		motor_d = motor_q;
		armed_d = armed_q;
		stall_cnt_d = stall_cnt_q;
		alarm_cnt_d = alarm_cnt_q;
		buzz_cnt_d = buzz_cnt_q;
		led_d = led_q;
		alarm_d = alarm_q;

		unique case (mode_q)
			msa_pkg::MODE_STOPPED: begin
				if (speed_valid) speed_d = speed_value;
				if (start_press && !stop_press) begin
					dir_d = (measured_dir == msa_pkg::DIR_BAD) ? msa_pkg::DIR_STOP : measured_dir;
					motor_d = 1'b1;
					armed_d = 1'b1;
					stall_cnt_d = '0;
					mode_d = msa_pkg::MODE_RUNNING;
				end
			end
			msa_pkg::MODE_RUNNING: begin
				if (stop_press) begin
					motor_d = 1'b0;
					armed_d = 1'b0;
					stall_cnt_d = '0;
					mode_d = msa_pkg::MODE_STOPPED;
				end else begin
					priority if (speed_valid) begin
						speed_d = speed_value;
					end else if (dir_toggle) begin
						dir_d = (measured_dir == msa_pkg::DIR_CW) ? msa_pkg::DIR_CCW
							: msa_pkg::DIR_CW;
					end else if (turning) begin
						armed_d = 1'b0;
						stall_cnt_d = '0;
					end else if (!armed_q) begin
						armed_d = 1'b1;
						stall_cnt_d = '0;
					end
					// count only while armed across the whole tick
					if (armed_q && armed_d) begin
						if (stall_hit) begin
							armed_d = 1'b0;
							stall_cnt_d = '0;
							alarm_cnt_d = '0;
							buzz_cnt_d = '0;
							alarm_d = 1'b0;
							mode_d = msa_pkg::MODE_ALARM;
						end else begin
							stall_cnt_d = stall_inc;
						end
					end
				end
			end
			msa_pkg::MODE_ALARM: begin
				priority if (stop_press) begin
					motor_d = 1'b0;
					led_d = 1'b0;
					alarm_d = 1'b0;
					mode_d = msa_pkg::MODE_STOPPED;
				end else if (turning) begin
					led_d = 1'b0;
					alarm_d = 1'b0;
					armed_d = 1'b0;
					stall_cnt_d = '0;
					mode_d = msa_pkg::MODE_RUNNING;
				end else begin
					alarm_cnt_d = alarm_inc;
					if (alarm_hit) begin
						led_d = 1'b1;
						alarm_d = 1'b1;
						motor_d = 1'b0;
						mode_d = msa_pkg::MODE_FAULT;
					end else if (buzz_hit) begin
						alarm_d = !alarm_q;
						buzz_cnt_d = '0;
					end else begin
						buzz_cnt_d = buzz_inc;
					end
				end
			end
			msa_pkg::MODE_FAULT: begin
				if (stop_press) begin
					led_d = 1'b0;
					alarm_d = 1'b0;
					mode_d = msa_pkg::MODE_STOPPED;
				end
			end
			default: ;
		endcase
	end

	// result: state after the tick, lowest field first
	assign res = {alarm_d, led_d, dir_d, speed_d, motor_d, mode_d};

`ifndef SYNTH
	a_motor_mode: assert property (@(posedge clk) disable iff (!arst_n)
		motor_q == (mode_q == msa_pkg::MODE_RUNNING || mode_q == msa_pkg::MODE_ALARM))
		else $error("motor enable disagrees with mode");
	a_led_fault: assert property (@(posedge clk) disable iff (!arst_n)
		led_q == (mode_q == msa_pkg::MODE_FAULT))
		else $error("fault LED disagrees with mode");
	a_armed_run: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |-> (mode_q == msa_pkg::MODE_RUNNING))
		else $error("stall timer armed outside running mode");
`endif

endmodule

`default_nettype wire

>>> rtl/core/motor_stall_alarm_fsm.sv
// Top level of the motor stall supervisor: input register, config regs, result register.
// Depends on msa_pkg, msa_cfg_regs and msa_core.
//
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tdata: one tick with button/speed/dir events and rpm
// m_axis    out  tvalid/tready          tdata: mode, drive, setpoint, direction, LED, buzzer
// cfg       in   cfg_valid/cfg_ready    cfg_index (register), cfg_data (16-bit value)
//
// One result beat per input beat, one beat per cycle sustained while m_axis_tready stays high.
// Path: the input register loads at the input accept edge; the single-pass state update
// then lands in the result register once that held beat is processed.
// Stalls: a held result blocks the input register, which then holds at most one beat.
// Reset clears the mode, timers, outputs and config to their defaults; no clearing pass.
// Config writes are always taken; they are meant to arrive only while the block is idle.
`default_nettype none

module motor_stall_alarm_fsm #(
	parameter int SPEED_BITS = msa_pkg::SPEED_BITS_DEF,
	parameter int TIMER_BITS = msa_pkg::TIMER_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,

	// tdata, lowest bit up: start_press, stop_press, speed_valid, speed_value,
	// dir_toggle, measured_dir, rpm_value, zero fill
	input  wire logic                                        s_axis_tvalid,
	output logic                                             s_axis_tready,
	input  wire logic [((msa_pkg::IN_FIXED_BITS+SPEED_BITS+7)/8)*8-1:0] s_axis_tdata,

	// tdata, lowest bit up: mode, motor_on, speed_out, dir_out, led_on, alarm_on, zero fill
	output logic                                             m_axis_tvalid,
	input  wire logic                                        m_axis_tready,
	output logic [((msa_pkg::RES_FIXED_BITS+SPEED_BITS+7)/8)*8-1:0] m_axis_tdata,

	input  wire logic                                        cfg_valid,
	output logic                                             cfg_ready,
	input  wire logic [1:0]                                  cfg_index,
	input  wire logic [msa_pkg::CFG_BITS-1:0]                cfg_data
);

	localparam int IN_BITS = msa_pkg::IN_FIXED_BITS + SPEED_BITS;
	localparam int RES_BITS = msa_pkg::RES_FIXED_BITS + SPEED_BITS;
	localparam int OUT_W = ((RES_BITS + 7) / 8) * 8;

	msa_pkg::cfg_regs_t cfg;

	assign cfg_ready = 1'b1;

	msa_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// input register
	logic                in_valid_s1;
	logic [IN_BITS-1:0]  in_item_s1;
	// result register
	logic                out_valid_q;
	logic [RES_BITS-1:0] out_res_q;

	logic step;      // the held beat is processed this cycle
	logic res_next;  // result register loads this cycle

	logic [RES_BITS-1:0] res;

	assign step = in_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) in_item_s1 <= s_axis_tdata[IN_BITS-1:0];
	end

	msa_core #(
		.SPEED_BITS (SPEED_BITS),
		.TIMER_BITS (TIMER_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cfg    (cfg),
		.item   (in_item_s1),
		.res    (res)
	);

	assign res_next = step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_next) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_next) out_res_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = OUT_W'(out_res_q);

`ifndef SYNTH
	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> m_axis_tvalid)
		else $error("processed beat produced no result");
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && !step) |=> (in_valid_s1 && $stable(in_item_s1)))
		else $error("waiting input beat lost or changed");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("waiting result beat lost or changed");
`endif

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for motor_stall_alarm_fsm: drives supervisor ticks, predicts each status beat.
// Depends on msa_pkg and the rtl/core modules only; no files, no arguments.

module tb;
	import msa_pkg::*;

	localparam int SPD_W = SPEED_BITS_DEF;
	localparam int TMR_W = TIMER_BITS_DEF;
	localparam int IN_W = ((IN_FIXED_BITS + SPD_W + 7) / 8) * 8;
	localparam int OUT_W = ((RES_FIXED_BITS + SPD_W + 7) / 8) * 8;

	// status beat layout, lowest bit up
	localparam int O_MOTOR = MODE_BITS;
	localparam int O_SPD = MODE_BITS + 1;
	localparam int O_DIR = O_SPD + SPD_W;
	localparam int O_LED = O_DIR + DIR_BITS;
	localparam int O_ALM = O_LED + 1;

	// watchdog limit, well above the longest expected run
	localparam int LIMIT_CYCLES = 300000;
	localparam int LONG_HOLD = 90;
	localparam int MAX_REPORTS = 60;
	// index with no register behind it; writes must be ignored
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	// receiver ready pattern, one bit per cycle
	localparam logic [6:0] RX_MASK = 7'b0101101;

	typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_HEAVY} rx_style_t;

	// packed so that start_press lands in bit 0 of tdata
	typedef struct packed {
		logic [RPM_BITS-1:0] rpm_value;
		logic [DIR_BITS-1:0] measured_dir;
		logic                dir_toggle;
		logic [SPD_W-1:0]    speed_value;
		logic                speed_valid;
		logic                stop_press;
		logic                start_press;
	} tick_t;

	typedef struct {
		mode_t               mode;
		logic                motor_on;
		logic [SPD_W-1:0]    speed_out;
		logic [DIR_BITS-1:0] dir_out;
		logic                led_on;
		logic                alarm_on;
	} status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;   // start, stop, speed_valid, speed, toggle, dir, rpm
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;       // mode, motor, speed, dir, led, alarm, fill
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [CFG_BITS-1:0] cfg_data = '0;

	motor_stall_alarm_fsm #(
		.SPEED_BITS(SPD_W),
		.TIMER_BITS(TMR_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Supervisor model state, reset values as after arst_n
	// ---------------------------------------------------------------
	mode_t               ps_mode = MODE_STOPPED;
	logic [SPD_W-1:0]    ps_speed = '0;
	logic [DIR_BITS-1:0] ps_dir = DIR_STOP;
	logic                ps_motor = 1'b0;
	logic                ps_armed = 1'b0;
	logic [TMR_W-1:0]    ps_stall_cnt = '0;
	logic [TMR_W-1:0]    ps_alarm_cnt = '0;
	logic [TMR_W-1:0]    ps_buzz_cnt = '0;
	logic                ps_led = 1'b0;
	logic                ps_buzzer = 1'b0;
	logic [CFG_BITS-1:0] lim_stall = STALL_TICKS_RST;
	logic [CFG_BITS-1:0] lim_alarm = ALARM_TICKS_RST;
	logic [CFG_BITS-1:0] lim_buzz = BUZZ_HALF_RST;

	status_t pending_status_q[$];

	// stimulus shaping
	rx_style_t rx_style = RX_OPEN;
	bit tx_gappy = 1'b0;
	int burst_left = 0;
	bit hold_pending = 1'b0;
	int hold_left = 0;
	int rx_step = 0;

	// bookkeeping
	int fail_count = 0;
	int cycle_count = 0;
	int n_ticks = 0;
	int n_checked = 0;
	int n_writes = 0;
	int n_alarms = 0;
	int n_faults = 0;
	int live_items = 0;

	// timers stop at all ones instead of wrapping
	function automatic logic [TMR_W-1:0] sat_inc(input logic [TMR_W-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	// One tick of the supervisor; updates the model state, returns the status after the tick
	function automatic status_t supervise_tick(input tick_t t);
		status_t r;
		logic was_armed;
		case (ps_mode)
			MODE_STOPPED: begin
				if (t.speed_valid)
					ps_speed = t.speed_value;
				if (t.start_press && !t.stop_press) begin
					// a bad detector code starts as stopped direction
					ps_dir = (t.measured_dir == DIR_BAD) ? DIR_STOP : t.measured_dir;
					ps_motor = 1'b1;
					ps_armed = 1'b1;
					ps_stall_cnt = '0;
					ps_mode = MODE_RUNNING;
				end
			end
			MODE_RUNNING: begin
				was_armed = ps_armed;
				if (t.stop_press) begin
					ps_motor = 1'b0;
					ps_armed = 1'b0;
					ps_stall_cnt = '0;
					ps_mode = MODE_STOPPED;
				end else begin
					// first event that holds wins
					if (t.speed_valid)
						ps_speed = t.speed_value;
					else if (t.dir_toggle)
						ps_dir = (t.measured_dir == DIR_CW) ? DIR_CCW : DIR_CW;
					else if (t.rpm_value != '0) begin
						ps_armed = 1'b0;
						ps_stall_cnt = '0;
					end else if (!ps_armed) begin
						ps_armed = 1'b1;
						ps_stall_cnt = '0;
					end
					// counts only when armed across the whole tick
					if (was_armed && ps_armed) begin
						ps_stall_cnt = sat_inc(ps_stall_cnt);
						if (ps_stall_cnt >= lim_stall) begin
							ps_armed = 1'b0;
							ps_stall_cnt = '0;
							ps_alarm_cnt = '0;
							ps_buzz_cnt = '0;
							ps_buzzer = 1'b0;
							ps_mode = MODE_ALARM;
						end
					end
				end
			end
			MODE_ALARM: begin
				if (t.stop_press) begin
					ps_motor = 1'b0;
					ps_led = 1'b0;
					ps_buzzer = 1'b0;
					ps_mode = MODE_STOPPED;
				end else if (t.rpm_value != '0) begin
					// motor came back: drop alarm, resume running
					ps_led = 1'b0;
					ps_buzzer = 1'b0;
					ps_armed = 1'b0;
					ps_stall_cnt = '0;
					ps_mode = MODE_RUNNING;
				end else begin
					ps_alarm_cnt = sat_inc(ps_alarm_cnt);
					if (ps_alarm_cnt >= lim_alarm) begin
						ps_led = 1'b1;
						ps_buzzer = 1'b1;
						ps_motor = 1'b0;
						ps_mode = MODE_FAULT;
					end else begin
						ps_buzz_cnt = sat_inc(ps_buzz_cnt);
						if (ps_buzz_cnt >= lim_buzz) begin
							ps_buzzer = ~ps_buzzer;
							ps_buzz_cnt = '0;
						end
					end
				end
			end
			default: begin
				// latched fault: only stop gets out
				if (t.stop_press) begin
					ps_led = 1'b0;
					ps_buzzer = 1'b0;
					ps_mode = MODE_STOPPED;
				end
			end
		endcase
		r.mode = ps_mode;
		r.motor_on = ps_motor;
		r.speed_out = ps_speed;
		r.dir_out = ps_dir;
		r.led_on = ps_led;
		r.alarm_on = ps_buzzer;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Drivers: all inputs change on the falling edge
	// ---------------------------------------------------------------
	task automatic send_tick(input tick_t t);
		mode_t was;
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = IN_W'(t);
		do @(posedge clk); while (!s_axis_tready);
		was = ps_mode;
		pending_status_q.push_back(supervise_tick(t));
		n_ticks++;
		// ticks that only hit an idle stopped block don't count as live
		if (was != MODE_STOPPED || t.start_press)
			live_items++;
		if (was != MODE_ALARM && ps_mode == MODE_ALARM)
			n_alarms++;
		if (was != MODE_FAULT && ps_mode == MODE_FAULT)
			n_faults++;
	endtask

	task automatic idle_gap(input int n);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// bursts of random length, random gaps between them
	task automatic send_paced(input tick_t t);
		send_tick(t);
		if (tx_gappy) begin
			if (burst_left == 0) begin
				idle_gap($urandom_range(1, 6));
				burst_left = $urandom_range(1, 12);
			end else
				burst_left--;
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_BITS-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_STALL_TICKS: lim_stall = val;
			CFG_ALARM_TICKS: lim_alarm = val;
			CFG_BUZZ_HALF:   lim_buzz = val;
			default: ;
		endcase
		n_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// sender stops, all status beats come back, then the pipeline idles before the bench goes on
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_status_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic tick_t mk_tick(input int start, input int stop, input int spd_v,
			input int spd, input int tog, input int mdir, input int rpm);
		tick_t t;
		t.start_press = start[0];
		t.stop_press = stop[0];
		t.speed_valid = spd_v[0];
		t.speed_value = spd[SPD_W-1:0];
		t.dir_toggle = tog[0];
		t.measured_dir = mdir[DIR_BITS-1:0];
		t.rpm_value = rpm[RPM_BITS-1:0];
		return t;
	endfunction

	// every field uniform over its full width
	function automatic tick_t noise_tick();
		return mk_tick($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
			$urandom_range(0, (1 << SPD_W) - 1), $urandom_range(0, 1),
			$urandom_range(0, 3), $urandom_range(0, 65535));
	endfunction

	// typical running tick: mostly stalled rpm, occasional events
	function automatic tick_t running_tick();
		tick_t t;
		int pick;
		t = noise_tick();
		t.start_press = ($urandom_range(0, 19) == 0);
		t.stop_press = ($urandom_range(0, 49) == 0);
		t.speed_valid = ($urandom_range(0, 9) == 0);
		t.dir_toggle = ($urandom_range(0, 9) == 0);
		pick = $urandom_range(0, 99);
		if (pick < 80)
			t.rpm_value = '0;
		else if (pick < 85)
			t.rpm_value = '1;
		else if (pick < 90)
			t.rpm_value = 16'd1;
		return t;
	endfunction

	// start, a run of running ticks of random length up to max_len, then stop
	task automatic run_episode(input int max_len);
		tick_t t;
		int len;
		len = $urandom_range(1, max_len);
		t = noise_tick();
		t.start_press = 1'b1;
		t.stop_press = ($urandom_range(0, 19) == 0);
		send_paced(t);
		repeat (len) send_paced(running_tick());
		t = noise_tick();
		t.stop_press = 1'b1;
		send_paced(t);
	endtask

	task automatic run_phase(input int stall, input int alarm, input int buzz,
			input rx_style_t rx, input bit gappy, input bit hold_first, input int target);
		int base;
		int max_len;
		wait_drained();
		write_reg(CFG_STALL_TICKS, CFG_BITS'(stall));
		write_reg(CFG_ALARM_TICKS, CFG_BITS'(alarm));
		write_reg(CFG_BUZZ_HALF, CFG_BITS'(buzz));
		rx_style = rx;
		tx_gappy = gappy;
		burst_left = $urandom_range(1, 12);
		if (hold_first)
			hold_pending = 1'b1;
		max_len = (stall + alarm + 8 > 40) ? 40 : stall + alarm + 8;
		base = live_items;
		while (live_items - base < target) begin
			if ($urandom_range(0, 99) < 15)
				send_paced(noise_tick());
			else
				run_episode(max_len);
		end
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// button, speed and direction handling at reset settings
	task automatic test_idle_and_run_events();
		rx_style = RX_RANDOM;
		tx_gappy = 1'b1;
		burst_left = 3;
		send_paced(mk_tick(0, 0, 1, 1023, 0, 0, 0));      // speed taken while stopped
		send_paced(mk_tick(0, 0, 0, 0, 1, DIR_CW, 0));    // toggle ignored while stopped
		send_paced(mk_tick(0, 1, 0, 0, 0, 0, 0));         // stop ignored while stopped
		send_paced(mk_tick(1, 1, 0, 0, 0, DIR_CW, 0));    // stop beats start
		send_paced(mk_tick(1, 0, 0, 0, 0, DIR_BAD, 0));   // bad detector code -> stopped dir
		send_paced(mk_tick(1, 0, 0, 0, 0, DIR_CW, 0));    // start ignored while running
		send_paced(mk_tick(0, 0, 0, 0, 1, DIR_CW, 0));    // cw -> ccw
		send_paced(mk_tick(0, 0, 0, 0, 1, DIR_CCW, 0));   // anything else -> cw
		send_paced(mk_tick(0, 0, 1, 0, 1, 0, 65535));     // speed wins over toggle and rpm
		send_paced(mk_tick(0, 0, 0, 0, 0, 0, 65535));     // turning disarms
		send_paced(mk_tick(1, 1, 0, 0, 0, 0, 0));         // stop from running
	endtask

	// stall -> alarm with buzzer toggles -> recovery -> stall again -> latched fault
	task automatic test_stall_escalation();
		wait_drained();
		write_reg(CFG_STALL_TICKS, 2);
		write_reg(CFG_ALARM_TICKS, 4);
		write_reg(CFG_BUZZ_HALF, 1);
		send_paced(mk_tick(1, 0, 0, 0, 0, DIR_CCW, 0));
		repeat (2) send_paced(mk_tick(0, 0, 0, 0, 0, 0, 0));
		send_paced(mk_tick(0, 0, 1, 341, 1, DIR_CW, 0));  // events ignored in alarm
		send_paced(mk_tick(0, 0, 0, 0, 0, 0, 1));         // rpm back -> running
		repeat (7) send_paced(mk_tick(0, 0, 0, 0, 0, 0, 0));
		send_paced(mk_tick(1, 0, 1, 682, 1, DIR_CW, 0));  // ignored in fault
		send_paced(mk_tick(0, 1, 0, 0, 0, 0, 0));         // stop clears the latch
	endtask

	// mixed traffic at ordinary settings
	task automatic test_random_supervision();
		run_phase(3, 12, 2, RX_RANDOM, 1'b1, 1'b0, 130);
		// back-to-back stretch with patterned receiver
		run_phase(5, 20, 3, RX_PATTERN, 1'b0, 1'b0, 120);
	endtask

	// limits at one, zero and all ones; write to an unmapped index
	task automatic test_timer_extremes();
		run_phase(1, 1, 1, RX_OPEN, 1'b1, 1'b0, 100);
		run_phase(0, 6, 0, RX_HEAVY, 1'b1, 1'b0, 70);
		wait_drained();
		write_reg(CFG_UNUSED, 16'hFFFF);
		run_phase(65535, 65535, 65535, RX_RANDOM, 1'b1, 1'b0, 60);
		run_phase(2, 65535, 65535, RX_OPEN, 1'b0, 1'b0, 60);
	endtask

	// receiver holds off while the sender keeps offering, so the input side stalls
	task automatic test_output_backpressure();
		run_phase(4, 30, 3, RX_RANDOM, 1'b0, 1'b1, 150);
	endtask

	// ---------------------------------------------------------------
	// Receiver: ready changes on the falling edge
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_pending) begin
			hold_left = LONG_HOLD;
			hold_pending = 1'b0;
		end
		rx_step = (rx_step == 6) ? 0 : rx_step + 1;
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready = 1'b0;
		end else begin
			case (rx_style)
				RX_OPEN:    m_axis_tready = 1'b1;
				RX_RANDOM:  m_axis_tready = ($urandom_range(0, 99) >= 30);
				RX_PATTERN: m_axis_tready = RX_MASK[rx_step];
				default:    m_axis_tready = ($urandom_range(0, 99) < 25);
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Checker: status beats sampled at the rising edge
	// ---------------------------------------------------------------
	task automatic flag_field(input string name, input int want, input int got);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
	endtask

	always @(posedge clk) begin : check_status
		status_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_status_q.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t ns: status beat with none pending, expected nothing, got %h",
						$time, m_axis_tdata);
			end else begin
				want = pending_status_q.pop_front();
				n_checked++;
				if (m_axis_tdata[MODE_BITS-1:0] != want.mode)
					flag_field("mode", want.mode, m_axis_tdata[MODE_BITS-1:0]);
				if (m_axis_tdata[O_MOTOR] != want.motor_on)
					flag_field("motor_on", want.motor_on, m_axis_tdata[O_MOTOR]);
				if (m_axis_tdata[O_SPD +: SPD_W] != want.speed_out)
					flag_field("speed_out", want.speed_out, m_axis_tdata[O_SPD +: SPD_W]);
				if (m_axis_tdata[O_DIR +: DIR_BITS] != want.dir_out)
					flag_field("dir_out", want.dir_out, m_axis_tdata[O_DIR +: DIR_BITS]);
				if (m_axis_tdata[O_LED] != want.led_on)
					flag_field("led_on", want.led_on, m_axis_tdata[O_LED]);
				if (m_axis_tdata[O_ALM] != want.alarm_on)
					flag_field("alarm_on", want.alarm_on, m_axis_tdata[O_ALM]);
			end
		end
	end

	// watchdog
	always @(posedge clk) cycle_count++;

	initial begin : watchdog
		wait (cycle_count >= LIMIT_CYCLES);
		$display("%0t ns: timeout, %0d status beats outstanding", $time,
			pending_status_q.size());
		$display("end of test: mismatches");
		$finish;
	end

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_and_run_events();
		test_stall_escalation();
		test_random_supervision();
		test_timer_extremes();
		test_output_backpressure();

		wait_drained();
		repeat (8) @(posedge clk);
		$display("run: %0d ticks in, %0d status beats checked, %0d register writes",
			n_ticks, n_checked, n_writes);
		$display("run: %0d stall alarms, %0d latched faults, limits from 0 to 65535",
			n_alarms, n_faults);
		if (fail_count == 0 && pending_status_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
